// ===== design/lps_pkg.sv =====
// Package for the five-point Laplacian stencil block.
// Holds the sizes, register indexes, reset values and the item struct shared by the modules that import it.
// No dependencies.
package lps_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int MAX_COLS        = 1024;
   localparam int ADDR_BITS       = $clog2(MAX_COLS);
   localparam int ROW_BITS        = 16;
   localparam int SUM_BITS        = SAMPLE_BITS + 2;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_IDX_BITS    = 2;
   localparam int COLS_FIELD_BITS = 11;

   localparam logic [CSR_IDX_BITS-1:0] REG_GRID_ROWS = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_GRID_COLS = CSR_IDX_BITS'(1);

   localparam int RESET_ROWS = 1024;
   localparam int RESET_COLS = 1024;
   localparam logic [ROW_BITS-1:0]  RESET_LAST_ROW = ROW_BITS'(RESET_ROWS - 1);
   localparam logic [ADDR_BITS-1:0] RESET_LAST_COL =
      ADDR_BITS'(((RESET_COLS > MAX_COLS) ? MAX_COLS : RESET_COLS) - 1);

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] south;
      logic signed [SAMPLE_BITS-1:0] center;
      logic signed [SAMPLE_BITS-1:0] west;
      logic [ROW_BITS-1:0]           row;
      logic [ADDR_BITS-1:0]          col;
      logic                          has_a;
      logic                          interior;
      logic                          has_b;
      logic                          last_b;
   } lps_item_type;

endpackage

// ===== design/lps_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read-first data.
// No dependencies.
module lps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lps_front.sv =====
// Front end of the stencil: config registers, raster counters, line store addressing
// and the first pipeline register. Depends on lps_pkg.
module lps_front
   import lps_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                          ram_en,
   output logic [ADDR_BITS-1:0]          ram_addr,
   output logic [ADDR_BITS-1:0]          east_addr,
   output logic [SAMPLE_BITS-1:0]        older_wdata,
   input  logic [SAMPLE_BITS-1:0]        newer_rdata,
   output logic                          item_valid,
   input  logic                          item_ready,
   output lps_item_type                  item
);

   logic [ROW_BITS-1:0]           row_ff;
   logic [ADDR_BITS-1:0]          col_ff;
   logic [ROW_BITS-1:0]           last_row_ff;
   logic [ADDR_BITS-1:0]          last_col_ff;
   logic                          fwd_ff;
   logic signed [SAMPLE_BITS-1:0] xprev_ff;
   logic signed [SAMPLE_BITS-1:0] west_ff;
   logic                          s1_valid_ff;
   lps_item_type                  s1_ff;

   logic                          accept;
   logic                          at_last_col;
   logic signed [SAMPLE_BITS-1:0] center_in;
   lps_item_type                  s1_in;
   logic [CSR_DATA_BITS-1:0]      cols_field;
   logic [CSR_DATA_BITS-1:0]      cols_eff;
   logic [ROW_BITS-1:0]           last_row_in;
   logic [ADDR_BITS-1:0]          last_col_in;

   assign req_ready = !s1_valid_ff || item_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      at_last_col = (col_ff == last_col_ff);
      east_addr   = at_last_col ? '0 : col_ff + 1'b1;
      center_in   = fwd_ff ? xprev_ff : $signed(newer_rdata);

      s1_in.south    = req_sample_in;
      s1_in.center   = center_in;
      s1_in.west     = west_ff;
      s1_in.row      = row_ff;
      s1_in.col      = col_ff;
      s1_in.has_a    = (row_ff != '0);
      s1_in.interior = (row_ff > ROW_BITS'(1)) && (col_ff != '0) && !at_last_col;
      s1_in.has_b    = (row_ff == last_row_ff);
      s1_in.last_b   = at_last_col;

      cols_field  = CSR_DATA_BITS'(csr_wdata[COLS_FIELD_BITS-1:0]);
      if (cols_field == '0) begin
         cols_eff = CSR_DATA_BITS'(1);
      end else if (cols_field > CSR_DATA_BITS'(MAX_COLS)) begin
         cols_eff = CSR_DATA_BITS'(MAX_COLS);
      end else begin
         cols_eff = cols_field;
      end
      last_col_in = ADDR_BITS'(cols_eff - CSR_DATA_BITS'(1));
      last_row_in = (csr_wdata == '0) ? '0 : ROW_BITS'(csr_wdata - CSR_DATA_BITS'(1));
   end

   assign ram_en      = accept;
   assign ram_addr    = col_ff;
   assign older_wdata = center_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         last_row_ff <= RESET_LAST_ROW;
         last_col_ff <= RESET_LAST_COL;
         fwd_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRID_ROWS: begin
                  last_row_ff <= last_row_in;
                  row_ff      <= '0;
                  col_ff      <= '0;
               end
               REG_GRID_COLS: begin
                  last_col_ff <= last_col_in;
                  row_ff      <= '0;
                  col_ff      <= '0;
               end
               default: begin
               end
            endcase
         end else if (accept) begin
            if (at_last_col) begin
               col_ff <= '0;
               row_ff <= (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (accept) begin
            fwd_ff      <= (east_addr == col_ff);
            s1_valid_ff <= 1'b1;
         end else if (item_ready) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff    <= s1_in;
         west_ff  <= center_in;
         xprev_ff <= req_sample_in;
      end
   end

   assign item_valid = s1_valid_ff;
   assign item       = s1_ff;

endmodule

// ===== design/lps_back.sv =====
// Back end of the stencil: neighbor sum, quarter, subtract with saturation, and the
// two-entry result register that emits up to two results per request. Depends on lps_pkg.
module lps_back
   import lps_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  lps_item_type                  item,
   input  logic [SAMPLE_BITS-1:0]        north,
   input  logic [SAMPLE_BITS-1:0]        east,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [ROW_BITS-1:0]           rsp_out_row,
   output logic [ADDR_BITS-1:0]          rsp_out_col,
   output logic                          rsp_saturated,
   output logic                          rsp_frame_last
);

   logic                          s2_valid_ff;
   lps_item_type                  s2_item_ff;
   logic signed [SUM_BITS-1:0]    s2_sum_ff;

   logic                          a_pend_ff;
   logic                          b_pend_ff;
   logic signed [SAMPLE_BITS-1:0] a_value_ff;
   logic                          a_sat_ff;
   logic signed [SAMPLE_BITS-1:0] b_value_ff;
   logic [ROW_BITS-1:0]           a_row_ff;
   logic [ROW_BITS-1:0]           b_row_ff;
   logic [ADDR_BITS-1:0]          col_ff;
   logic                          last_ff;

   logic signed [SUM_BITS-1:0]    sum_in;
   logic signed [SUM_BITS-1:0]    quarter;
   logic signed [SUM_BITS-1:0]    diff_wide;
   logic [SAMPLE_BITS:0]          diff;
   logic                          sat_hi;
   logic                          sat_lo;
   logic signed [SAMPLE_BITS-1:0] a_value_in;
   logic                          a_sat_in;
   logic                          out_take;
   logic                          s2_ready;

   always_comb begin
      sum_in = $signed({{2{north[SAMPLE_BITS-1]}}, north})
             + $signed({{2{east[SAMPLE_BITS-1]}}, east})
             + SUM_BITS'(item.south)
             + SUM_BITS'(item.west);

      quarter   = s2_sum_ff >>> 2;
      diff_wide = SUM_BITS'(s2_item_ff.center) - quarter;
      diff      = diff_wide[SAMPLE_BITS:0];
      sat_hi    = !diff[SAMPLE_BITS] && diff[SAMPLE_BITS-1];
      sat_lo    = diff[SAMPLE_BITS] && !diff[SAMPLE_BITS-1];

      if (!s2_item_ff.interior) begin
         a_value_in = s2_item_ff.center;
         a_sat_in   = 1'b0;
      end else if (sat_hi) begin
         a_value_in = SAMPLE_MAX;
         a_sat_in   = 1'b1;
      end else if (sat_lo) begin
         a_value_in = SAMPLE_MIN;
         a_sat_in   = 1'b1;
      end else begin
         a_value_in = $signed(diff[SAMPLE_BITS-1:0]);
         a_sat_in   = 1'b0;
      end
   end

   assign rsp_valid  = a_pend_ff || b_pend_ff;
   assign out_take   = !rsp_valid || (rsp_ready && (a_pend_ff != b_pend_ff));
   assign s2_ready   = !s2_valid_ff || out_take;
   assign item_ready = s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         a_pend_ff   <= 1'b0;
         b_pend_ff   <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= item_valid;
         end
         if (s2_valid_ff && out_take) begin
            a_pend_ff <= s2_item_ff.has_a;
            b_pend_ff <= s2_item_ff.has_b;
         end else if (rsp_valid && rsp_ready) begin
            if (a_pend_ff) begin
               a_pend_ff <= 1'b0;
            end else begin
               b_pend_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && item_valid) begin
         s2_item_ff <= item;
         s2_sum_ff  <= sum_in;
      end
      if (s2_valid_ff && out_take) begin
         a_value_ff <= a_value_in;
         a_sat_ff   <= a_sat_in;
         b_value_ff <= s2_item_ff.south;
         a_row_ff   <= s2_item_ff.row - 1'b1;
         b_row_ff   <= s2_item_ff.row;
         col_ff     <= s2_item_ff.col;
         last_ff    <= s2_item_ff.last_b;
      end
   end

   assign rsp_sample_out = a_pend_ff ? a_value_ff : b_value_ff;
   assign rsp_out_row    = a_pend_ff ? a_row_ff : b_row_ff;
   assign rsp_out_col    = col_ff;
   assign rsp_saturated  = a_pend_ff && a_sat_ff;
   assign rsp_frame_last = !a_pend_ff && last_ff;

endmodule

// ===== design/laplacian_five_point_stencil.sv =====
// Five-point Laplacian stencil on a row-major sample stream.
// Channels: req_ carries one grid sample per request, rsp_ carries result points
// with their row and column, a saturation flag and a last-point mark; csr_ writes
// grid_rows (index 0) and grid_cols (index 1), and any such write restarts the grid.
// A request in row r+1 yields point (r,c); a last-row request past row 0 also yields its
// own border point, so it produces two results. Border points pass through unchanged.
// Throughput: one request per cycle while rsp_ready is high; a two-result request holds
// the pipeline while its results leave. The rate is set by the two line store RAMs, each
// read and written once per request. Results pass the s1, s2 and result registers in order.
// Reset clears the counters and sets a 1024 x 1024 grid; there is no clearing pass,
// line store entries are only used after the current grid has written them.
// When rsp_ready is low, results hold in the output register and the pipeline
// fills; req_ready falls once the three stages are full. csr_ready is always high.
// Depends on lps_pkg, lps_front, lps_ram and lps_back.
module laplacian_five_point_stencil
   import lps_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [ROW_BITS-1:0]           rsp_out_row,
   output logic [ADDR_BITS-1:0]          rsp_out_col,
   output logic                          rsp_saturated,
   output logic                          rsp_frame_last
);

   logic                   ram_en;
   logic [ADDR_BITS-1:0]   ram_addr;
   logic [ADDR_BITS-1:0]   east_addr;
   logic [SAMPLE_BITS-1:0] older_wdata;
   logic [SAMPLE_BITS-1:0] older_rdata;
   logic [SAMPLE_BITS-1:0] newer_rdata;
   logic                   item_valid;
   logic                   item_ready;
   lps_item_type           item;

   lps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .ram_en        (ram_en),
      .ram_addr      (ram_addr),
      .east_addr     (east_addr),
      .older_wdata   (older_wdata),
      .newer_rdata   (newer_rdata),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item)
   );

   lps_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_COLS)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (ram_en),
      .wr_addr (ram_addr),
      .wr_data (older_wdata),
      .rd_en   (ram_en),
      .rd_addr (ram_addr),
      .rd_data (older_rdata)
   );

   lps_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_COLS)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (ram_en),
      .wr_addr (ram_addr),
      .wr_data (req_sample_in),
      .rd_en   (ram_en),
      .rd_addr (east_addr),
      .rd_data (newer_rdata)
   );

   lps_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item),
      .north          (older_rdata),
      .east           (newer_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_saturated  (rsp_saturated),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ===== dv/lps_stencil_checker.sv =====
// Scoreboard for laplacian_five_point_stencil: follows the grid position and both line
// stores, predicts the result points of every request and compares them in order.
// Depends on lps_pkg.
module lps_stencil_checker
   import lps_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic [ROW_BITS-1:0]           rsp_out_row,
   input  logic [ADDR_BITS-1:0]          rsp_out_col,
   input  logic                          rsp_saturated,
   input  logic                          rsp_frame_last,
   output int                            mismatches,
   output int                            points_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [ROW_BITS-1:0]           row;
      logic [ADDR_BITS-1:0]          col;
      logic                          saturated;
      logic                          frame_last;
   } grid_point_t;

   logic signed [SAMPLE_BITS-1:0] older_line [MAX_COLS];
   logic signed [SAMPLE_BITS-1:0] newer_line [MAX_COLS];
   int unsigned                   grid_rows;
   int unsigned                   grid_cols;
   int unsigned                   row_at;
   int unsigned                   col_at;
   grid_point_t                   points_due [$];

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("%0t lps_stencil_checker: %s", $time, what);
   endtask

   task automatic predict_points(input logic signed [SAMPLE_BITS-1:0] x);
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      int unsigned c;
      longint      acc;
      longint      neighbor_sum;
      logic        clipped;
      rows = (grid_rows == 0) ? 1 : grid_rows;
      cols = (grid_cols == 0) ? 1 : grid_cols;
      if (cols > MAX_COLS)
         cols = MAX_COLS;
      if (row_at >= rows || col_at >= cols) begin
         row_at = 0;
         col_at = 0;
      end
      r = row_at;
      c = col_at;
      if (r >= 1) begin
         acc     = newer_line[c];
         clipped = 1'b0;
         if (r >= 2 && c >= 1 && c + 1 < cols) begin
            neighbor_sum = longint'(older_line[c]) + longint'(x)
                         + longint'(older_line[c-1]) + longint'(newer_line[c+1]);
            acc = acc - (neighbor_sum >>> 2);
            if (acc > SAMPLE_MAX) begin
               acc     = SAMPLE_MAX;
               clipped = 1'b1;
            end else if (acc < SAMPLE_MIN) begin
               acc     = SAMPLE_MIN;
               clipped = 1'b1;
            end
         end
         points_due.push_back('{SAMPLE_BITS'(acc), ROW_BITS'(r - 1), ADDR_BITS'(c),
                                clipped, 1'b0});
      end
      older_line[c] = newer_line[c];
      newer_line[c] = x;
      if (r == rows - 1)
         points_due.push_back('{x, ROW_BITS'(r), ADDR_BITS'(c), 1'b0, c == cols - 1});
      if (c + 1 >= cols) begin
         col_at = 0;
         row_at = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
         col_at = c + 1;
      end
   endtask

   always @(posedge clock) begin : track
      grid_point_t want;
      if (reset) begin
         grid_rows  = RESET_ROWS;
         grid_cols  = RESET_COLS;
         row_at     = 0;
         col_at     = 0;
         mismatches = 0;
         points_due.delete();
         foreach (older_line[i]) begin
            older_line[i] = '0;
            newer_line[i] = '0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (points_due.size() == 0) begin
               note_mismatch($sformatf("point (%0d,%0d) value %0d arrived with none expected",
                                       rsp_out_row, rsp_out_col, rsp_sample_out));
            end else begin
               want = points_due.pop_front();
               if (rsp_sample_out !== want.sample)
                  note_mismatch($sformatf("sample_out at (%0d,%0d): expected %0d, got %0d",
                                          want.row, want.col, $signed(want.sample),
                                          rsp_sample_out));
               if (rsp_out_row !== want.row)
                  note_mismatch($sformatf("out_row: expected %0d, got %0d",
                                          want.row, rsp_out_row));
               if (rsp_out_col !== want.col)
                  note_mismatch($sformatf("out_col at row %0d: expected %0d, got %0d",
                                          want.row, want.col, rsp_out_col));
               if (rsp_saturated !== want.saturated)
                  note_mismatch($sformatf("saturated at (%0d,%0d): expected %0b, got %0b",
                                          want.row, want.col, want.saturated,
                                          rsp_saturated));
               if (rsp_frame_last !== want.frame_last)
                  note_mismatch($sformatf("frame_last at (%0d,%0d): expected %0b, got %0b",
                                          want.row, want.col, want.frame_last,
                                          rsp_frame_last));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRID_ROWS: begin
                  grid_rows = csr_wdata;
                  row_at    = 0;
                  col_at    = 0;
               end
               REG_GRID_COLS: begin
                  grid_cols = csr_wdata[COLS_FIELD_BITS-1:0];
                  row_at    = 0;
                  col_at    = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_points(req_sample_in);
      end
      points_pending <= points_due.size();
   end

endmodule

// ===== dv/laplacian_five_point_stencil_tb.sv =====
// Top of the laplacian_five_point_stencil testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Checking lives in lps_stencil_checker.
// Depends on lps_pkg, lps_stencil_checker and the block itself.
module laplacian_five_point_stencil_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lps_pkg::*;

   localparam int                      CYCLE_LIMIT   = 1_000_000;
   localparam int                      LONG_HOLD     = 200;
   localparam int                      SETTLE_CYCLES = 8;
   localparam int                      RANDOM_ITEMS  = 420;
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED    = CSR_IDX_BITS'(2);

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_in  = '0;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index      = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata      = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic [ROW_BITS-1:0]           rsp_out_row;
   logic [ADDR_BITS-1:0]          rsp_out_col;
   logic                          rsp_saturated;
   logic                          rsp_frame_last;
   int                            mismatches;
   int                            points_pending;

   bit                            calm        = 1'b0;
   int                            hold_asked  = 0;
   int                            hold_served = 0;
   int                            cycles      = 0;

   // three rows of five: two interior points clip high, one clips low
   logic signed [SAMPLE_BITS-1:0] corner_grid [15] = '{
      24'sd0,     SAMPLE_MIN, SAMPLE_MAX, -24'sd3,    SAMPLE_MAX,
      SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 24'sd5,
      -24'sd1,    SAMPLE_MIN, SAMPLE_MAX, 24'sd0,     SAMPLE_MIN
   };

   laplacian_five_point_stencil DUT (.*);
   lps_stencil_checker scoreboard (.*);

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("laplacian_five_point_stencil_tb: FAIL");
         $finish;
      end
   end

   function automatic int idle_len();
      int pick;
      if (calm)
         return 0;
      pick = $urandom_range(0, 19);
      if (pick < 11)
         return 0;
      if (pick < 18)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val, input bit keep_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (!keep_valid)
         csr_valid <= 1'b0;
   endtask

   task automatic program_grid(input logic [CSR_DATA_BITS-1:0] rows_word,
                               input logic [CSR_DATA_BITS-1:0] cols_word);
      if ($urandom_range(0, 1)) begin
         write_csr(REG_GRID_ROWS, rows_word, 1'b1);
         write_csr(REG_GRID_COLS, cols_word, 1'b0);
      end else begin
         write_csr(REG_GRID_COLS, cols_word, 1'b1);
         write_csr(REG_GRID_ROWS, rows_word, 1'b0);
      end
   endtask

   // drop valid, drain every expected point, then let row-zero requests leave the pipe
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (points_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : result_side
      int   left;
      logic level;
      left  = 0;
      level = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            level       = 1'b0;
            left        = LONG_HOLD;
         end else if (left != 0) begin
            left--;
         end else if (level) begin
            left  = idle_len();
            level = (left == 0);
            if (level)
               left = $urandom_range(1, 30);
         end else begin
            level = 1'b1;
            left  = $urandom_range(1, 30);
         end
         rsp_ready <= level;
      end
   end

   initial begin : stimulus
      int                       rows;
      int                       cols;
      int                       count;
      int                       fed;
      int                       phase;
      logic [CSR_DATA_BITS-1:0] cols_word;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_grid(16'd3, 16'd5);
      foreach (corner_grid[i])
         push_sample(corner_grid[i]);
      settle();

      // a write to an unused index must not restart the grid
      program_grid(16'd2, 16'd2);
      push_sample(24'sd7);
      push_sample(-24'sd7);
      settle();
      write_csr(REG_UNUSED, 16'hFFFF, 1'b0);
      push_sample(24'sd1);
      push_sample(-24'sd256);
      settle();

      program_grid(16'd0, 16'd0);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      settle();

      program_grid(16'd1, 16'hFFFF);
      push_sample(24'sd100);
      push_sample(-24'sd100);
      push_sample(24'sd0);
      settle();

      fed   = 0;
      phase = 0;
      while (fed < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       rows = 0;
            1:       rows = $urandom_range(7, 40);
            default: rows = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 9))
            0:       cols = 0;
            1:       cols = $urandom_range(13, 40);
            default: cols = $urandom_range(1, 12);
         endcase
         cols_word = {CSR_DATA_BITS'($urandom)} & ~CSR_DATA_BITS'(11'h7FF)
                   | CSR_DATA_BITS'(cols);
         count = $urandom_range(4, 60);
         calm  = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            calm  = 1'b1;
            count = 80;
            program_grid(16'd4, 16'd6);
            hold_asked++;
         end else begin
            case ($urandom_range(0, 3))
               0:       write_csr(REG_GRID_ROWS, CSR_DATA_BITS'(rows), 1'b0);
               1:       write_csr(REG_GRID_COLS, cols_word, 1'b0);
               default: program_grid(CSR_DATA_BITS'(rows), cols_word);
            endcase
         end
         repeat (count)
            push_sample(draw_sample());
         fed += count;
         phase++;
         settle();
      end

      calm = 1'b0;
      program_grid(16'hFFFF, 16'd3);
      repeat (40)
         push_sample(draw_sample());
      settle();

      program_grid(16'd1, 16'h07FF);
      repeat (60)
         push_sample(draw_sample());
      settle();

      if (mismatches == 0 && points_pending == 0)
         $display("laplacian_five_point_stencil_tb: PASS");
      else
         $display("laplacian_five_point_stencil_tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
design/lps_pkg.sv
design/lps_ram.sv
design/lps_front.sv
design/lps_back.sv
design/laplacian_five_point_stencil.sv
dv/lps_stencil_checker.sv
dv/laplacian_five_point_stencil_tb.sv
